// ===== sv/aslru_pkg.sv =====
package aslru_pkg;

  localparam int ADDR_W        = 24;
  localparam int TIME_W        = 48;
  localparam int SLOT_W        = 6;
  localparam int OUTC_W        = 3;
  localparam int DEFAULT_DEPTH = 64;

  typedef enum logic [OUTC_W-1:0] {
    OUTC_HIT     = 3'd0,
    OUTC_EMPTY   = 3'd1,
    OUTC_EVICT   = 3'd2,
    OUTC_HOME    = 3'd3,
    OUTC_IGNORED = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_DECIDE,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] stamp;
  } slot_t;

endpackage

// ===== sv/address_slot_table_lru.sv =====
// A miss probes every slot from the home slot onward; when TABLE_DEPTH is not a power of
// two, the home slot is first found by reciprocal multiplication. A hit finishes early,
// and a zero address skips the scan. One item is in work at a time; the slot memory, read
// once a cycle, sets the rate. After reset a clearing pass zeroes the table.
module address_slot_table_lru #(
  parameter int TABLE_DEPTH = aslru_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [aslru_pkg::ADDR_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [aslru_pkg::ADDR_W-1:0]  in_address,
  input  logic [aslru_pkg::TIME_W-1:0]  in_time_now,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [aslru_pkg::SLOT_W-1:0]  out_slot_index,
  output aslru_pkg::outcome_t           out_outcome,
  output logic [aslru_pkg::ADDR_W-1:0]  out_evicted_address
);
  import aslru_pkg::*;

  localparam int  IDX_W      = $clog2(TABLE_DEPTH);
  localparam int  CNT_W      = IDX_W + 1;
  localparam bit  DEPTH_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  // Rounded-down reciprocal of the depth, scaled by two to the address width. The quotient
  // it gives is at most one short, so one compare and subtract finishes the remainder.
  localparam logic [ADDR_W-1:0] RECIP = ADDR_W'((1 << ADDR_W) / TABLE_DEPTH);

  // The slot table: one word per slot holding the address and its last-seen stamp.
  // Written at one address, read at one address, read data registered.
  slot_t mem [TABLE_DEPTH];
  slot_t mem_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  slot_t             mem_wd;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  pinned_r;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [ADDR_W-1:0]  quo_r, quo_nxt;
  logic               mod_ph_r, mod_ph_nxt;
  logic [IDX_W-1:0]   home_r, home_nxt;
  logic [ADDR_W-1:0]  home_addr_r, home_addr_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   iss_cnt_r, iss_cnt_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               cmp_first_r, cmp_first_nxt;
  logic               cmp_last_r, cmp_last_nxt;
  logic               have_empty_r, have_empty_nxt;
  logic [IDX_W-1:0]   empty_idx_r, empty_idx_nxt;
  logic               have_lru_r, have_lru_nxt;
  logic [IDX_W-1:0]   lru_idx_r, lru_idx_nxt;
  logic [TIME_W-1:0]  lru_stamp_r, lru_stamp_nxt;
  logic [ADDR_W-1:0]  lru_addr_r, lru_addr_nxt;
  logic [IDX_W-1:0]   chosen_r, chosen_nxt;
  outcome_t           outcome_r, outcome_nxt;
  logic [ADDR_W-1:0]  evicted_r, evicted_nxt;
  logic               res_wr_r, res_wr_nxt;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  outcome_t           out_outc_r, out_outc_nxt;
  logic [ADDR_W-1:0]  out_ev_r, out_ev_nxt;

  logic               in_xfer;
  logic               out_free;
  logic               issue;
  logic [2*ADDR_W-1:0] mod_prod;
  logic [CNT_W-1:0]   mod_t;
  logic [CNT_W-1:0]   mod_red;
  logic               slot_pinned;

  assign in_stall  = state_r != ST_IDLE;
  assign in_xfer   = in_valid && !in_stall;
  // The result register can take a new result when it is empty or being emptied.
  assign out_free  = !out_valid_r || !out_stall;
  assign issue     = (state_r == ST_SCAN) && (iss_cnt_r < CNT_W'(TABLE_DEPTH));

  assign out_valid           = out_valid_r;
  assign out_slot_index      = out_slot_r;
  assign out_outcome         = out_outc_r;
  assign out_evicted_address = out_ev_r;

  // Home slot for a depth that is not a power of two. The first phase registers the
  // approximate quotient; the second forms the remainder in the low CNT_W bits, where it is
  // below twice the depth, and subtracts the depth once if it is still too large.
  assign mod_prod = (2*ADDR_W)'(addr_r) * (2*ADDR_W)'(RECIP);
  assign mod_t    = addr_r[CNT_W-1:0] - CNT_W'(quo_r[CNT_W-1:0] * CNT_W'(TABLE_DEPTH));
  assign mod_red  = (mod_t >= CNT_W'(TABLE_DEPTH)) ? (mod_t - CNT_W'(TABLE_DEPTH)) : mod_t;

  assign slot_pinned = (pinned_r != '0) && (mem_q.addr == pinned_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pinned_r <= '0;
    end else if (cfg_wr_en) begin
      pinned_r <= cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    time_nxt       = time_r;
    quo_nxt        = quo_r;
    mod_ph_nxt     = mod_ph_r;
    home_nxt       = home_r;
    home_addr_nxt  = home_addr_r;
    rd_idx_nxt     = rd_idx_r;
    iss_cnt_nxt    = iss_cnt_r;
    have_empty_nxt = have_empty_r;
    empty_idx_nxt  = empty_idx_r;
    have_lru_nxt   = have_lru_r;
    lru_idx_nxt    = lru_idx_r;
    lru_stamp_nxt  = lru_stamp_r;
    lru_addr_nxt   = lru_addr_r;
    chosen_nxt     = chosen_r;
    outcome_nxt    = outcome_r;
    evicted_nxt    = evicted_r;
    res_wr_nxt     = res_wr_r;
    clr_idx_nxt    = clr_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_slot_nxt   = out_slot_r;
    out_outc_nxt   = out_outc_r;
    out_ev_nxt     = out_ev_r;
    mem_we         = 1'b0;
    mem_wa         = chosen_r;
    mem_wd         = '{addr: addr_r, stamp: time_r};

    // The read issued in this cycle is compared in the next one.
    cmp_vld_nxt    = issue;
    cmp_idx_nxt    = rd_idx_r;
    cmp_first_nxt  = iss_cnt_r == '0;
    cmp_last_nxt   = iss_cnt_r == CNT_W'(TABLE_DEPTH - 1);

    if (issue) begin
      iss_cnt_nxt = iss_cnt_r + 1'b1;
      rd_idx_nxt  = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_idx_r;
        mem_wd      = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          addr_nxt       = in_address;
          time_nxt       = in_time_now;
          have_empty_nxt = 1'b0;
          have_lru_nxt   = 1'b0;
          iss_cnt_nxt    = '0;
          if (in_address == '0) begin
            chosen_nxt  = '0;
            outcome_nxt = OUTC_IGNORED;
            evicted_nxt = '0;
            res_wr_nxt  = 1'b0;
            state_nxt   = ST_WRITE;
          end else if (DEPTH_POW2) begin
            home_nxt   = in_address[IDX_W-1:0];
            rd_idx_nxt = in_address[IDX_W-1:0];
            state_nxt  = ST_SCAN;
          end else begin
            mod_ph_nxt = 1'b0;
            state_nxt  = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        if (!mod_ph_r) begin
          quo_nxt    = mod_prod[2*ADDR_W-1:ADDR_W];
          mod_ph_nxt = 1'b1;
        end else begin
          home_nxt    = mod_red[IDX_W-1:0];
          rd_idx_nxt  = mod_red[IDX_W-1:0];
          iss_cnt_nxt = '0;
          state_nxt   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (cmp_vld_r) begin
          if (mem_q.addr == addr_r) begin
            chosen_nxt  = cmp_idx_r;
            outcome_nxt = OUTC_HIT;
            evicted_nxt = '0;
            res_wr_nxt  = 1'b1;
            state_nxt   = ST_WRITE;
          end else begin
            if (cmp_first_r) begin
              home_addr_nxt = mem_q.addr;
            end
            if (!have_empty_r && mem_q.addr == '0) begin
              have_empty_nxt = 1'b1;
              empty_idx_nxt  = cmp_idx_r;
            end
            // Strictly older wins, so ties stay with the earlier slot in probe order.
            if (!slot_pinned && (!have_lru_r || mem_q.stamp < lru_stamp_r)) begin
              have_lru_nxt  = 1'b1;
              lru_idx_nxt   = cmp_idx_r;
              lru_stamp_nxt = mem_q.stamp;
              lru_addr_nxt  = mem_q.addr;
            end
            if (cmp_last_r) begin
              state_nxt = ST_DECIDE;
            end
          end
        end
      end

      ST_DECIDE: begin
        res_wr_nxt = 1'b1;
        state_nxt  = ST_WRITE;
        if (have_empty_r) begin
          chosen_nxt  = empty_idx_r;
          outcome_nxt = OUTC_EMPTY;
          evicted_nxt = '0;
        end else if (have_lru_r) begin
          chosen_nxt  = lru_idx_r;
          outcome_nxt = OUTC_EVICT;
          evicted_nxt = lru_addr_r;
        end else begin
          chosen_nxt  = home_r;
          outcome_nxt = OUTC_HOME;
          evicted_nxt = home_addr_r;
        end
      end

      ST_WRITE: begin
        if (out_free) begin
          mem_we        = res_wr_r;
          out_valid_nxt = 1'b1;
          out_slot_nxt  = SLOT_W'(chosen_r);
          out_outc_nxt  = outcome_r;
          out_ev_nxt    = evicted_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      iss_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    time_r       <= time_nxt;
    quo_r        <= quo_nxt;
    mod_ph_r     <= mod_ph_nxt;
    home_r       <= home_nxt;
    home_addr_r  <= home_addr_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    cmp_first_r  <= cmp_first_nxt;
    cmp_last_r   <= cmp_last_nxt;
    have_empty_r <= have_empty_nxt;
    empty_idx_r  <= empty_idx_nxt;
    have_lru_r   <= have_lru_nxt;
    lru_idx_r    <= lru_idx_nxt;
    lru_stamp_r  <= lru_stamp_nxt;
    lru_addr_r   <= lru_addr_nxt;
    chosen_r     <= chosen_nxt;
    outcome_r    <= outcome_nxt;
    evicted_r    <= evicted_nxt;
    res_wr_r     <= res_wr_nxt;
    out_slot_r   <= out_slot_nxt;
    out_outc_r   <= out_outc_nxt;
    out_ev_r     <= out_ev_nxt;
  end

endmodule

// ===== sv/aslru_chk.sv =====
module aslru_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [aslru_pkg::SLOT_W-1:0]  out_slot_index,
  input aslru_pkg::outcome_t           out_outcome,
  input logic [aslru_pkg::ADDR_W-1:0]  out_evicted_address
);
  import aslru_pkg::*;

  // The table is being cleared straight after reset, so no input is taken.
  a_clear_stall: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> in_stall)
    else $error("input taken during the clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_slot_index) &&
      $stable(out_outcome) && $stable(out_evicted_address)))
    else $error("stalled result changed");

  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome == OUTC_IGNORED) |->
      (out_slot_index == '0 && out_evicted_address == '0))
    else $error("ignored item reports a slot or an eviction");

  a_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome == OUTC_HIT || out_outcome == OUTC_EMPTY)) |->
      (out_evicted_address == '0))
    else $error("hit or empty claim reports an eviction");

  a_evict_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome == OUTC_EVICT) |-> (out_evicted_address != '0))
    else $error("eviction of an empty slot reported");

endmodule

bind address_slot_table_lru aslru_chk u_aslru_chk (.*);

// ===== bench/slot_table_sb_pkg.sv =====
package slot_table_sb_pkg;
  import aslru_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    outcome_t          outcome;
    logic [ADDR_W-1:0] evicted;
  } lookup_result_t;

  class slot_table_sb;
    logic [ADDR_W-1:0] pinned;
    logic [ADDR_W-1:0] slot_addr  [DEFAULT_DEPTH];
    logic [TIME_W-1:0] slot_stamp [DEFAULT_DEPTH];
    lookup_result_t    expected_lookups[$];
    int unsigned       failures;
    int unsigned       pinned_writes;
    int unsigned       outcome_count[5];

    function new();
      pinned = '0;
      failures = 0;
      pinned_writes = 0;
      foreach (outcome_count[i]) outcome_count[i] = 0;
      foreach (slot_addr[i]) begin
        slot_addr[i] = '0;
        slot_stamp[i] = '0;
      end
    endfunction

    function void write_pinned(logic [ADDR_W-1:0] value);
      pinned = value;
      pinned_writes++;
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction

    // Probes the slots from the home slot onward until a hit or the last slot, and updates the table copy.
    function lookup_result_t predict_lookup(logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] stamp);
      int unsigned home, idx, empty_idx, lru_idx, chosen;
      bit have_empty, have_lru;
      lookup_result_t r;
      r.slot = '0;
      r.outcome = OUTC_IGNORED;
      r.evicted = '0;
      have_empty = 1'b0;
      have_lru = 1'b0;
      empty_idx = 0;
      lru_idx = 0;
      if (addr == '0) return r;
      home = addr % DEFAULT_DEPTH;
      for (int step = 0; step < DEFAULT_DEPTH; step++) begin
        idx = (home + step) % DEFAULT_DEPTH;
        if (slot_addr[idx] == addr) begin
          slot_stamp[idx] = stamp;
          r.slot = SLOT_W'(idx);
          r.outcome = OUTC_HIT;
          return r;
        end
        if (!have_empty && slot_addr[idx] == '0) begin
          have_empty = 1'b1;
          empty_idx = idx;
        end
        if (pinned != '0 && slot_addr[idx] == pinned) continue;
        if (!have_lru || slot_stamp[idx] < slot_stamp[lru_idx]) begin
          have_lru = 1'b1;
          lru_idx = idx;
        end
      end
      if (have_empty) begin
        chosen = empty_idx;
        r.outcome = OUTC_EMPTY;
      end else if (have_lru) begin
        chosen = lru_idx;
        r.outcome = OUTC_EVICT;
        r.evicted = slot_addr[chosen];
      end else begin
        chosen = home;
        r.outcome = OUTC_HOME;
        r.evicted = slot_addr[chosen];
      end
      slot_addr[chosen] = addr;
      slot_stamp[chosen] = stamp;
      r.slot = SLOT_W'(chosen);
      return r;
    endfunction

    function void note_lookup(logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] stamp);
      expected_lookups.push_back(predict_lookup(addr, stamp));
    endfunction

    function void check_lookup(logic [SLOT_W-1:0] slot, outcome_t outcome,
                               logic [ADDR_W-1:0] evicted);
      lookup_result_t exp_r;
      if (expected_lookups.size() == 0) begin
        $error("result transfer with no lookup outstanding: slot_index %0d", slot);
        failures++;
        return;
      end
      exp_r = expected_lookups.pop_front();
      outcome_count[int'(exp_r.outcome)]++;
      if (slot !== exp_r.slot) begin
        $error("slot_index: expected %0d, got %0d", exp_r.slot, slot);
        failures++;
      end
      if (outcome !== exp_r.outcome) begin
        $error("outcome: expected %0d, got %0d", exp_r.outcome, outcome);
        failures++;
      end
      if (evicted !== exp_r.evicted) begin
        $error("evicted_address: expected %06h, got %06h", exp_r.evicted, evicted);
        failures++;
      end
    endfunction
  endclass

endpackage

// ===== bench/address_slot_table_lru_tb.sv =====
module address_slot_table_lru_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aslru_pkg::*;
  import slot_table_sb_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [ADDR_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [ADDR_W-1:0] in_address;
  logic [TIME_W-1:0] in_time_now;
  logic              out_valid;
  logic              out_stall;
  logic [SLOT_W-1:0] out_slot_index;
  outcome_t          out_outcome;
  logic [ADDR_W-1:0] out_evicted_address;

  // Shared by both sides: while set, neither the sender nor the receiver idles.
  bit                calm = 1'b0;
  // Running timestamp for random lookups; it mostly creeps forward in small steps so
  // that equal stamps, and hence ties for the least recently seen slot, occur often.
  logic [TIME_W-1:0] stamp_clock;

  slot_table_sb sb = new();

  address_slot_table_lru DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_address         (in_address),
    .in_time_now        (in_time_now),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_slot_index     (out_slot_index),
    .out_outcome        (out_outcome),
    .out_evicted_address(out_evicted_address)
  );

  always #5 clk = ~clk;

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 19);
  endfunction

  // One lookup transfer. Idle cycles go in front of the item, and the payload is held
  // steady until the block lowers its stall at a rising edge. The prediction is made at
  // the edge of the transfer, so the table copy moves in step with the block.
  task automatic send_lookup(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] stamp);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_address <= addr;
    in_time_now <= stamp;
    do @(posedge clk); while (in_stall);
    sb.note_lookup(addr, stamp);
  endtask

  // Holds the sender back until every outstanding result has been taken, and then longer,
  // so that the block has finished its write-back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pinned(input logic [ADDR_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.write_pinned(value);
    cfg_wr_en <= 1'b0;
  endtask

  // A random phase. Most lookups draw from a pool that is larger than the table, so the
  // table fills and evictions follow; part of the pool is crowded onto four home slots
  // to force long probe runs and wrapping. The rest is noise: zero addresses, fully
  // random addresses and occasional random timestamps anywhere in the 48-bit range.
  task automatic run_phase(input int items, input int pool_len, input int noise_pct,
                           input logic [ADDR_W-1:0] seed_addr);
    logic [ADDR_W-1:0] pool[$];
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] stamp;
    int                roll;
    if (seed_addr != '0) pool.push_back(seed_addr);
    while (pool.size() < pool_len) begin
      addr = ADDR_W'($urandom);
      if ($urandom_range(0, 2) == 0)
        addr[SLOT_W-1:0] = ($urandom_range(0, 3) == 3) ? SLOT_W'(DEFAULT_DEPTH - 1)
                                                       : SLOT_W'($urandom_range(0, 2));
      if (addr == '0) addr = ADDR_W'(1);
      pool.push_back(addr);
    end
    for (int k = 0; k < items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < noise_pct / 2)
        addr = '0;
      else if (roll < noise_pct)
        addr = ADDR_W'($urandom);
      else
        addr = pool[$urandom_range(0, pool.size() - 1)];
      stamp_clock = stamp_clock + TIME_W'($urandom_range(0, 2));
      if ($urandom_range(0, 99) < 4)
        stamp = TIME_W'({$urandom, $urandom});
      else
        stamp = stamp_clock;
      send_lookup(addr, stamp);
    end
  endtask

  // Result side: takes a result at every edge where it is offered and not stalled, and
  // decides the stall for the next cycle with a single assignment per edge.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_lookup(out_slot_index, out_outcome, out_evicted_address);
      out_stall <= take_break();
    end
  end

  // Generous limit: about 500 lookups plus idling come to well under 0.5 ms, and the
  // clearing pass after reset is tiny by comparison.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int waited;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    in_address <= '0;
    in_time_now <= '0;
    out_stall <= 1'b0;
    stamp_clock = TIME_W'(1000);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with nothing pinned. It covers the ignored zero address, both
    // extremes of address and time, alternating bit patterns, a hit, wrapping from the
    // last slot to slot 0, and several addresses sharing one home slot.
    write_pinned('0);
    send_lookup('0, TIME_W'(5));
    send_lookup({ADDR_W{1'b1}}, {TIME_W{1'b1}});
    send_lookup({ADDR_W{1'b1}}, '0);
    send_lookup(ADDR_W'(DEFAULT_DEPTH - 1), TIME_W'(10));
    send_lookup(ADDR_W'(2 * DEFAULT_DEPTH - 1), TIME_W'(11));
    send_lookup(ADDR_W'(DEFAULT_DEPTH), TIME_W'(12));
    send_lookup(ADDR_W'(1), TIME_W'(13));
    send_lookup(ADDR_W'(DEFAULT_DEPTH), TIME_W'(14));
    send_lookup('0, {TIME_W{1'b1}});
    send_lookup(24'h800000, TIME_W'(15));
    send_lookup(24'h555555, 48'h5555_5555_5555);
    send_lookup(24'hAAAAAA, 48'hAAAA_AAAA_AAAA);
    send_lookup(24'h555555, 48'hAAAA_AAAA_AAAA);
    send_lookup(ADDR_W'(2 * DEFAULT_DEPTH - 1), TIME_W'(16));
    send_lookup(24'h000040, TIME_W'(17));
    send_lookup(24'h800001, TIME_W'(17));
    send_lookup(24'hFFFFC0, TIME_W'(18));
    send_lookup(ADDR_W'(1), TIME_W'(19));

    // The highest address is pinned and sits in the table with the oldest stamp, so the
    // evictions of this phase must pass over it.
    wait_drained();
    write_pinned({ADDR_W{1'b1}});
    run_phase(160, 90, 6, {ADDR_W{1'b1}});

    // Pin an address that is most likely resident, and run a stretch with no idling on
    // either side.
    wait_drained();
    write_pinned(sb.slot_addr[$urandom_range(0, DEFAULT_DEPTH - 1)]);
    calm = 1'b1;
    run_phase(160, 100, 6, '0);
    calm = 1'b0;

    // Back to nothing pinned, with more noise in the stimulus.
    wait_drained();
    write_pinned('0);
    run_phase(160, 75, 16, '0);

    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DEFAULT_DEPTH + 8) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d lookups never returned a result", sb.pending());
      sb.failures += sb.pending();
    end

    $display("Run covered %0d hits, %0d empty claims, %0d evictions, %0d home reuses",
             sb.outcome_count[OUTC_HIT], sb.outcome_count[OUTC_EMPTY],
             sb.outcome_count[OUTC_EVICT], sb.outcome_count[OUTC_HOME]);
    $display("and %0d zero addresses, across %0d writes of the pinned address.",
             sb.outcome_count[OUTC_IGNORED], sb.pinned_writes);
    if (sb.failures == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
